// ----- hw/rtl/fafc_pkg.sv -----
// ============================================================================
// fafc_pkg
// Shared types and opcodes for the fully associative FIFO-replacement cache.
// ============================================================================
package fafc_pkg;

  // Operation codes carried in the opcode field
  localparam logic [1:0] OP_READ    = 2'd0;
  localparam logic [1:0] OP_WRITE   = 2'd1;
  localparam logic [1:0] OP_PRELOAD = 2'd2;

  // Commands from the sequencer to the datapath
  typedef struct packed {
    logic load;    // capture the input beat
    logic div;     // register the block address (tag)
    logic lookup;  // compare tags, start a fill or write the backing store
    logic fill;    // step the block fill
    logic access;  // read or write the cached word
    logic resp;    // load the output register
  } ctrl_cmd_t;

  // Status from the datapath to the sequencer
  typedef struct packed {
    logic is_rw;      // current op is a read or a write
    logic hit;        // tag matched a valid entry
    logic fill_done;  // last word of the block is being written
    logic out_free;   // output register can take a result this cycle
  } dp_status_t;

endpackage

// ----- hw/rtl/fafc_ctrl.sv -----
// ============================================================================
// fafc_ctrl
// Sequencer: steps one item through decode, lookup, fill, access, response.
// ============================================================================
module fafc_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  fafc_pkg::dp_status_t  status_i,
  output fafc_pkg::ctrl_cmd_t   cmd_o
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_DIV    = 6'b000010,
    ST_LOOKUP = 6'b000100,
    ST_FILL   = 6'b001000,
    ST_ACCESS = 6'b010000,
    ST_RESP   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div = 1'b1;
        state_d   = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        cmd_o.lookup = 1'b1;
        if (!status_i.is_rw) begin
          state_d = ST_RESP;
        end else if (status_i.hit) begin
          state_d = ST_ACCESS;
        end else begin
          state_d = ST_FILL;
        end
      end
      ST_FILL: begin
        cmd_o.fill = 1'b1;
        if (status_i.fill_done) begin
          state_d = ST_ACCESS;
        end
      end
      ST_ACCESS: begin
        cmd_o.access = 1'b1;
        state_d      = ST_RESP;
      end
      ST_RESP: begin
        if (status_i.out_free) begin
          cmd_o.resp = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // An accepted beat closes the input until the response is loaded
  a_accept_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted twice in a row");

  // A fill is entered only after a lookup miss on a read or write
  a_fill_after_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_LOOKUP && status_i.is_rw && !status_i.hit |=> state_q == ST_FILL)
    else $error("miss did not start a fill");

  // A response is produced only while the output side can take it
  a_resp_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.resp |-> status_i.out_free)
    else $error("response loaded while output busy");

endmodule

// ----- hw/rtl/fafc_datapath.sv -----
// ============================================================================
// fafc_datapath
// Tags, valid bits, FIFO pointer, cached words, backing store, output register.
// ============================================================================
module fafc_datapath #(
  parameter int unsigned NUM_ENTRIES = 4,
  parameter int unsigned BLOCK_WORDS = 4,
  parameter int unsigned ADDR_BITS   = 6
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  fafc_pkg::ctrl_cmd_t   cmd_i,
  output fafc_pkg::dp_status_t  status_o,
  input  logic [1:0]            opcode_i,
  input  logic [ADDR_BITS-1:0]  address_i,
  input  logic [7:0]            write_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [7:0]            read_data_o,
  output logic                  hit_o,
  output logic [1:0]            entry_used_o
);

  localparam int unsigned IDX_W    = $clog2(NUM_ENTRIES);
  localparam int unsigned OFF_W    = $clog2(BLOCK_WORDS);
  localparam int unsigned CNT_W    = $clog2(BLOCK_WORDS + 1);
  localparam int unsigned TAG_RAW  = $clog2(((1 << ADDR_BITS) - 1) / BLOCK_WORDS + 1);
  localparam int unsigned TAG_W    = (TAG_RAW < 1) ? 1 : TAG_RAW;
  localparam int unsigned WORDS    = NUM_ENTRIES * BLOCK_WORDS;
  localparam int unsigned WA_W     = $clog2(WORDS);
  localparam int unsigned STORE    = 1 << ADDR_BITS;
  localparam int unsigned SHIFT    = ADDR_BITS + OFF_W;
  localparam int unsigned PROD_W   = 2 * ADDR_BITS + 1;
  localparam logic [63:0] RECIP_64 =
    ((64'd1 << SHIFT) + 64'(BLOCK_WORDS) - 64'd1) / 64'(BLOCK_WORDS);
  localparam logic [PROD_W-1:0] RECIP = RECIP_64[PROD_W-1:0];

  // Captured item
  logic [1:0]           op_q;
  logic [ADDR_BITS-1:0] addr_q;
  logic [7:0]           wdata_q;
  logic [TAG_W-1:0]     tag_q;
  logic                 hit_q;
  logic [IDX_W-1:0]     entry_q;

  // Cache state
  logic [NUM_ENTRIES-1:0] valid_q;
  logic [TAG_W-1:0]       tags_q [NUM_ENTRIES];
  logic [IDX_W-1:0]       fifo_q, fifo_nxt;

  // Fill sequencing
  logic [CNT_W-1:0] fill_cnt_q;
  logic             pend_q;
  logic [OFF_W-1:0] widx_q;
  logic             cnt_end;

  // Memories
  logic [7:0] words_mem [WORDS];
  logic [7:0] store_mem [STORE];
  logic [7:0] bs_rd_q;
  logic [7:0] words_rd_q;

  // Output register
  logic       out_valid_q;
  logic [7:0] read_data_q;
  logic       hit_out_q;
  logic [1:0] entry_out_q;

  logic [PROD_W-1:0]      prod;
  logic [TAG_W-1:0]       quot;
  logic [ADDR_BITS-1:0]   base;
  logic [OFF_W-1:0]       off;
  logic [ADDR_BITS-1:0]   fill_addr;
  logic [WA_W-1:0]        entry_base;
  logic [WA_W-1:0]        acc_addr;
  logic [WA_W-1:0]        fill_waddr;
  logic [NUM_ENTRIES-1:0] match_vec;
  logic                   match_any;
  logic [IDX_W-1:0]       match_idx;
  logic                   is_rw;
  logic                   is_read;
  logic                   miss_start;

  // Block address by reciprocal multiply, exact for every ADDR_BITS-wide address
  assign prod = PROD_W'(addr_q) * RECIP;
  assign quot = TAG_W'(prod >> SHIFT);

  assign base       = ADDR_BITS'(ADDR_BITS'(tag_q) * ADDR_BITS'(BLOCK_WORDS));
  assign off        = OFF_W'(addr_q - base);
  assign fill_addr  = ADDR_BITS'(base + ADDR_BITS'(fill_cnt_q));
  assign entry_base = WA_W'(WA_W'(entry_q) * WA_W'(BLOCK_WORDS));
  assign acc_addr   = WA_W'(entry_base + WA_W'(off));
  assign fill_waddr = WA_W'(entry_base + WA_W'(widx_q));

  assign is_read    = (op_q == fafc_pkg::OP_READ);
  assign is_rw      = is_read || (op_q == fafc_pkg::OP_WRITE);
  assign miss_start = cmd_i.lookup && is_rw && !match_any;
  assign cnt_end    = (fill_cnt_q == CNT_W'(BLOCK_WORDS));
  assign fifo_nxt   = (fifo_q == IDX_W'(NUM_ENTRIES - 1)) ? '0 : fifo_q + 1'b1;

  // Tag compare on all entries; lowest index wins
  always_comb begin
    match_any = 1'b0;
    match_idx = '0;
    for (int e = 0; e < NUM_ENTRIES; e++) begin
      match_vec[e] = valid_q[e] && (tags_q[e] == tag_q);
    end
    for (int e = NUM_ENTRIES - 1; e >= 0; e--) begin
      if (match_vec[e]) begin
        match_any = 1'b1;
        match_idx = IDX_W'(e);
      end
    end
  end

  assign status_o.is_rw     = is_rw;
  assign status_o.hit       = match_any;
  assign status_o.fill_done = pend_q && cnt_end;
  assign status_o.out_free  = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      fifo_q      <= '0;
      fill_cnt_q  <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (miss_start) begin
        fifo_q            <= fifo_nxt;
        valid_q[fifo_nxt] <= 1'b1;
        fill_cnt_q        <= '0;
        pend_q            <= 1'b0;
      end else if (cmd_i.fill) begin
        pend_q <= !cnt_end;
        if (!cnt_end) begin
          fill_cnt_q <= fill_cnt_q + 1'b1;
        end
      end
      if (cmd_i.resp) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= opcode_i;
      addr_q  <= address_i;
      wdata_q <= write_data_i;
    end
    if (cmd_i.div) begin
      tag_q <= quot;
    end
    if (cmd_i.lookup && is_rw) begin
      if (match_any) begin
        entry_q <= match_idx;
        hit_q   <= 1'b1;
      end else begin
        entry_q          <= fifo_nxt;
        hit_q            <= 1'b0;
        tags_q[fifo_nxt] <= tag_q;
      end
    end
    if (cmd_i.fill && !cnt_end) begin
      widx_q <= OFF_W'(fill_cnt_q);
    end
    if (cmd_i.resp) begin
      read_data_q <= is_read ? words_rd_q : 8'd0;
      hit_out_q   <= is_rw ? hit_q : 1'b0;
      entry_out_q <= is_rw ? 2'(entry_q) : 2'd0;
    end
  end

  // Backing store: preload writes, fill reads, never both at once
  always_ff @(posedge clk_i) begin
    if (cmd_i.lookup && (op_q == fafc_pkg::OP_PRELOAD)) begin
      store_mem[addr_q] <= wdata_q;
    end
    if (cmd_i.fill && !cnt_end) begin
      bs_rd_q <= store_mem[fill_addr];
    end
  end

  // Cached words: fill or write on one port, word read on the other
  always_ff @(posedge clk_i) begin
    if (cmd_i.fill && pend_q) begin
      words_mem[fill_waddr] <= bs_rd_q;
    end else if (cmd_i.access && !is_read) begin
      words_mem[acc_addr] <= wdata_q;
    end
    if (cmd_i.access) begin
      words_rd_q <= words_mem[acc_addr];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign read_data_o  = read_data_q;
  assign hit_o        = hit_out_q;
  assign entry_used_o = entry_out_q;

  // Valid entries never share a tag
  a_unique_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.lookup |-> $onehot0(match_vec))
    else $error("several entries match one tag");

  // A miss allocates a now-valid victim and reports no hit
  a_miss_alloc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    miss_start |=> valid_q[entry_q] && !hit_q && (entry_q == fifo_q))
    else $error("miss did not allocate the FIFO victim");

  // A waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.resp |-> !out_valid_q || !out_stall_i)
    else $error("result overwritten while stalled");

endmodule

// ----- hw/rtl/fully_associative_fifo_cache.sv -----
// ============================================================================
// fully_associative_fifo_cache
// Fully associative cache with FIFO replacement over a byte-wide backing store.
// ============================================================================
// Each input beat is a word read, a word write or a preload of one backing-store
// byte, and each gives exactly one result beat. The block works on one item at
// a time: a hit passes from acceptance to the result register through capture,
// block-address decode, tag compare, word access and response, and a preload or
// an unused opcode skips the word access. A miss adds a block fill between the
// tag compare and the word access, in which the single-port backing store hands
// over to the cache one word per cycle with
// a registered read. A result waits in the output register while out_stall_i
// is high; the next item is accepted once the previous one has been moved into
// that register. On a miss the FIFO pointer advances first and then names the
// victim, so the first miss after reset fills entry 1. Writes stay in the cache
// and never reach the backing store. Reading a block whose bytes were never
// preloaded returns undefined data. No clearing pass is needed after reset.
module fully_associative_fifo_cache #(
  parameter int unsigned NUM_ENTRIES = 4,
  parameter int unsigned BLOCK_WORDS = 4,
  parameter int unsigned ADDR_BITS   = 6
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // request beats
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           opcode_i,
  input  logic [ADDR_BITS-1:0] address_i,
  input  logic [7:0]           write_data_i,
  // result beats
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [7:0]           read_data_o,
  output logic                 hit_o,
  output logic [1:0]           entry_used_o
);

  fafc_pkg::ctrl_cmd_t  cmd;
  fafc_pkg::dp_status_t status;

  // Sequencer: hold the input closed from capture until the result is loaded
  fafc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Datapath: tag store, FIFO pointer, word memory, backing store, output reg
  fafc_datapath #(
    .NUM_ENTRIES (NUM_ENTRIES),
    .BLOCK_WORDS (BLOCK_WORDS),
    .ADDR_BITS   (ADDR_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .opcode_i     (opcode_i),
    .address_i    (address_i),
    .write_data_i (write_data_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .read_data_o  (read_data_o),
    .hit_o        (hit_o),
    .entry_used_o (entry_used_o)
  );

endmodule
